@@ rtl/core/grid_min_path_cost_dp_assert.svh @@
// ---------------------------------------------------------------------------
// grid_min_path_cost_dp assertion macros
// shared concurrent assertion forms used by the grid path cost core
// ---------------------------------------------------------------------------
`ifndef GRID_MIN_PATH_COST_DP_ASSERT_SVH
`define GRID_MIN_PATH_COST_DP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmp assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define GMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmp assertion failed: next-cycle implication");

`endif

@@ rtl/core/gmp_pkg.sv @@
// ---------------------------------------------------------------------------
// gmp_pkg
// types, codes and helpers shared by the grid path cost core
// ---------------------------------------------------------------------------
package gmp_pkg;

    localparam int COST_W   = 16;
    localparam int WEIGHT_W = 8;
    localparam int FROM_W   = 2;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int SIZE_W   = 13;

    // predecessor codes
    localparam logic [FROM_W-1:0] FROM_LEFT  = 2'd0;
    localparam logic [FROM_W-1:0] FROM_BELOW = 2'd1;
    localparam logic [FROM_W-1:0] FROM_START = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd10;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last;
    } t_pos_info;

    // sizes below 2 count as 2, above the maximum count as the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] w;
        begin
            w = {{(SIZE_W-CFG_W){1'b0}}, v};
            if (w < SIZE_W'(2)) begin
                clamp_size = SIZE_W'(2);
            end else if (w > maxv) begin
                clamp_size = maxv;
            end else begin
                clamp_size = w;
            end
        end
    endfunction

endpackage

@@ rtl/core/gmp_line_buf.sv @@
// ---------------------------------------------------------------------------
// gmp_line_buf
// line buffer holding the lower row's costs, one read and one write port
// ---------------------------------------------------------------------------
module gmp_line_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [gmp_pkg::COST_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [gmp_pkg::COST_W-1:0] i_wr_data
);

    logic [gmp_pkg::COST_W-1:0] r_mem [DEPTH];
    logic [gmp_pkg::COST_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/gmp_pos_ctrl.sv @@
// ---------------------------------------------------------------------------
// gmp_pos_ctrl
// grid size registers and row/column position tracking
// ---------------------------------------------------------------------------
module gmp_pos_ctrl #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int CPW = 6,
    parameter int RPW = 6,
    parameter int CCW = 7,
    parameter int RCW = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gmp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_advance,
    output logic [CPW-1:0]                o_col,
    output gmp_pkg::t_pos_info            o_info
);

    logic [CPW-1:0] r_col, n_col;
    logic [RPW-1:0] r_row, n_row;
    logic [CCW-1:0] r_cols;
    logic [RCW-1:0] r_rows;
    logic           end_col;
    logic           end_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RCW'(gmp_pkg::clamp_size(gmp_pkg::SIZE_RESET,
                                               gmp_pkg::SIZE_W'(MAX_ROWS)));
            r_cols <= CCW'(gmp_pkg::clamp_size(gmp_pkg::SIZE_RESET,
                                               gmp_pkg::SIZE_W'(MAX_COLS)));
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gmp_pkg::CFG_NUM_ROWS: begin
                    r_rows <= RCW'(gmp_pkg::clamp_size(i_cfg_data,
                                                       gmp_pkg::SIZE_W'(MAX_ROWS)));
                end
                gmp_pkg::CFG_NUM_COLS: begin
                    r_cols <= CCW'(gmp_pkg::clamp_size(i_cfg_data,
                                                       gmp_pkg::SIZE_W'(MAX_COLS)));
                end
                default: begin
                end
            endcase
        end
    end

    // a position at or past the last one counts as the last
    assign end_col = ((CCW'(r_col) + CCW'(1)) >= r_cols);
    assign end_row = ((RCW'(r_row) + RCW'(1)) >= r_rows);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (end_col) begin
                n_col = '0;
                n_row = end_row ? '0 : r_row + RPW'(1);
            end else begin
                n_col = r_col + CPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col            = r_col;
    assign o_info.first_row = (r_row == '0);
    assign o_info.first_col = (r_col == '0);
    assign o_info.last      = end_col && end_row;

endmodule

@@ rtl/core/gmp_acs.sv @@
// ---------------------------------------------------------------------------
// gmp_acs
// saturating add-compare-select for one grid cell
// ---------------------------------------------------------------------------
module gmp_acs (
    input  logic [gmp_pkg::COST_W-1:0]   i_left_cost,
    input  logic [gmp_pkg::COST_W-1:0]   i_below_cost,
    input  logic [gmp_pkg::WEIGHT_W-1:0] i_right_weight,
    input  logic [gmp_pkg::WEIGHT_W-1:0] i_down_weight,
    input  gmp_pkg::t_pos_info           i_info,
    output logic [gmp_pkg::COST_W-1:0]   o_cost,
    output logic [gmp_pkg::FROM_W-1:0]   o_came_from
);

    logic [gmp_pkg::COST_W:0]   sum_left;
    logic [gmp_pkg::COST_W:0]   sum_below;
    logic [gmp_pkg::COST_W-1:0] via_left;
    logic [gmp_pkg::COST_W-1:0] via_below;

    assign sum_left  = {1'b0, i_left_cost}
                     + {{(gmp_pkg::COST_W-gmp_pkg::WEIGHT_W+1){1'b0}}, i_right_weight};
    assign sum_below = {1'b0, i_below_cost}
                     + {{(gmp_pkg::COST_W-gmp_pkg::WEIGHT_W+1){1'b0}}, i_down_weight};

    // saturate at all ones
    assign via_left  = sum_left[gmp_pkg::COST_W]  ? '1 : sum_left[gmp_pkg::COST_W-1:0];
    assign via_below = sum_below[gmp_pkg::COST_W] ? '1 : sum_below[gmp_pkg::COST_W-1:0];

    always_comb begin
        if (i_info.first_row && i_info.first_col) begin
            o_cost      = '0;
            o_came_from = gmp_pkg::FROM_START;
        end else if (i_info.first_row) begin
            o_cost      = via_left;
            o_came_from = gmp_pkg::FROM_LEFT;
        end else if (i_info.first_col) begin
            o_cost      = via_below;
            o_came_from = gmp_pkg::FROM_BELOW;
        end else if (via_left < via_below) begin
            o_cost      = via_left;
            o_came_from = gmp_pkg::FROM_LEFT;
        end else begin
            // ties go to below
            o_cost      = via_below;
            o_came_from = gmp_pkg::FROM_BELOW;
        end
    end

endmodule

@@ rtl/core/grid_min_path_cost_dp.sv @@
// ---------------------------------------------------------------------------
// grid_min_path_cost_dp
// streaming minimal path cost through a rows-by-columns grid
// ---------------------------------------------------------------------------
// Cells arrive bottom row first, left to right within a row, one transaction
// per cell; each cell yields one result transaction with its minimal path
// cost from the bottom-left start, the direction the path came from, and a
// last flag on the top-right cell. The core takes one cell per clock when the
// output side keeps up; a result leaves stage one for the output register. The
// rate is set by the line buffer, a single memory of MAX_COLS entries with one
// read and one write per cycle: the read of the lower row's cost is issued as
// the cell is accepted, and the add-compare-select result is written back as
// it moves into the output register. Consecutive cells always sit in different
// columns, so the read and write of one cycle never meet at the same entry.
// The line buffer has no clearing pass; every entry used was written by the
// row below. Grid size registers are to be written only while the core is idle
// (not enforced by the core itself) and take effect on the next cell.
// ---------------------------------------------------------------------------
module grid_min_path_cost_dp #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gmp_pkg::CFG_W-1:0]       i_cfg_data,
    // cell input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gmp_pkg::WEIGHT_W-1:0]    i_right_weight,
    input  logic [gmp_pkg::WEIGHT_W-1:0]    i_down_weight,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gmp_pkg::COST_W-1:0]      o_path_cost,
    output logic [gmp_pkg::FROM_W-1:0]      o_came_from,
    output logic                            o_last
);

`include "grid_min_path_cost_dp_assert.svh"

    // column index, row index and size count widths
    localparam int CPW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);

    logic                        in_acc;
    logic                        s1_adv;
    logic [CPW-1:0]              cur_col;
    gmp_pkg::t_pos_info          cur_info;
    logic [gmp_pkg::COST_W-1:0]  below_cost;
    logic [gmp_pkg::COST_W-1:0]  cell_cost;
    logic [gmp_pkg::FROM_W-1:0]  cell_from;

    // stage one: cell waiting on the line buffer read
    logic                           r_s1_valid;
    logic [gmp_pkg::WEIGHT_W-1:0]   r_s1_rw;
    logic [gmp_pkg::WEIGHT_W-1:0]   r_s1_dw;
    logic [CPW-1:0]                 r_s1_col;
    gmp_pkg::t_pos_info             r_s1_info;

    // cost of the cell to the left
    logic [gmp_pkg::COST_W-1:0]     r_left;

    // output register
    logic                           r_out_valid;
    logic [gmp_pkg::COST_W-1:0]     r_out_cost;
    logic [gmp_pkg::FROM_W-1:0]     r_out_from;
    logic                           r_out_last;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // stage one moves on when the output register is empty or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    gmp_pos_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CPW      (CPW),
        .RPW      (RPW),
        .CCW      (CCW),
        .RCW      (RCW)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (in_acc),
        .o_col       (cur_col),
        .o_info      (cur_info)
    );

    // lower row costs: read at accept, written when the cell leaves stage one
    gmp_line_buf #(
        .DEPTH (MAX_COLS),
        .AW    (CPW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_col),
        .o_rd_data (below_cost),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (cell_cost)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rw   <= i_right_weight;
            r_s1_dw   <= i_down_weight;
            r_s1_col  <= cur_col;
            r_s1_info <= cur_info;
        end
    end

    gmp_acs u_acs (
        .i_left_cost    (r_left),
        .i_below_cost   (below_cost),
        .i_right_weight (r_s1_rw),
        .i_down_weight  (r_s1_dw),
        .i_info         (r_s1_info),
        .o_cost         (cell_cost),
        .o_came_from    (cell_from)
    );

    // left cost follows the cell that just finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (s1_adv) begin
            r_left <= cell_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_cost <= cell_cost;
            r_out_from <= cell_from;
            r_out_last <= r_s1_info.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_path_cost = r_out_cost;
    assign o_came_from = r_out_from;
    assign o_last      = r_out_last;

    // read and write of the line buffer never hit the same entry together
    `GMP_ASSERT_IMPLY(a_no_rw_collide, i_clk, i_rst_n, in_acc && s1_adv, cur_col != r_s1_col)
    // a stalled cell in stage one is kept
    `GMP_ASSERT_NEXT(a_s1_kept, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid)
    // the start cell always costs nothing
    `GMP_ASSERT_IMPLY(a_start_zero, i_clk, i_rst_n, r_out_valid && (r_out_from == gmp_pkg::FROM_START), r_out_cost == '0)
    // the top-right cell is never the start cell
    `GMP_ASSERT_IMPLY(a_last_not_start, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_from != gmp_pkg::FROM_START)

endmodule
